// ----- hdl/lrd_pkg.sv -----
// Shared types and constants for the LZRW1 run-length decompressor.
package lrd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
  localparam int PROD_W       = HIST_AW + 1;
  localparam int CNT_W        = 17;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);

  localparam logic [7:0]  HDR_STORED = 8'h80;
  localparam logic [7:0]  LEN_MASK   = 8'h0f;
  localparam logic [4:0]  CTRL_BITS  = 5'd16;
  localparam logic [4:0]  COPY_MIN   = 5'd3;
  localparam logic [16:0] RUN_MIN    = 17'd16;

  typedef enum logic [2:0] {
    PH_HEADER, PH_CTRL_HI, PH_CTRL_LO, PH_TOKEN, PH_SECOND, PH_RUN_LO, PH_RUN_VAL
  } phase_t;

  typedef enum logic [1:0] {CMD_LIT, CMD_COPY, CMD_RUN, CMD_MARK} cmd_kind_t;

  typedef enum logic [1:0] {BK_IDLE, BK_READ, BK_WRITE, BK_FILL} bk_state_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [7:0]          data;
    logic [HIST_AW-1:0]  pos;
    logic [CNT_W-1:0]    count;
    logic [PROD_W-1:0]   fill;
    logic                bad;
    logic                fend;
  } cmd_t;

endpackage

// ----- hdl/lrd_if.sv -----
// Handshake interfaces for compressed input and decompressed output items.
interface lrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_first;
  logic       frame_last;
  modport source (output valid, in_byte, frame_first, frame_last, input ready);
  modport sink   (input valid, in_byte, frame_first, frame_last, output ready);
endinterface

interface lrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [16:0] repeat_count;
  logic        last_of_item;
  logic        frame_end;
  logic        bad_offset;
  modport source (output valid, out_byte, repeat_count, last_of_item, frame_end,
                  bad_offset, input ready);
  modport sink   (input valid, out_byte, repeat_count, last_of_item, frame_end,
                  bad_offset, output ready);
endinterface

// ----- hdl/lrd_front.sv -----
// Frame parser: turns compressed bytes into literal, copy, run and marker commands.
module lrd_front import lrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       frame_first,
  input  logic       frame_last,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  phase_t              phase, phase_next;
  logic                stored, stored_next;
  logic [15:0]         ctrl, ctrl_next;
  logic [4:0]          bits_left, bits_left_next;
  logic [7:0]          tok0, tok0_next, tok1, tok1_next, tok2, tok2_next;
  logic [PROD_W-1:0]   produced, produced_next;

  logic                accept, ignore, tdone;
  logic [PROD_W-1:0]   add;
  logic [PROD_W:0]     sum;
  logic [HIST_AW-1:0]  pos;
  logic [4:0]          bl_dec;
  logic [16:0]         run_count;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;
  assign pos      = {tok0, in_byte[7:4]};
  assign bl_dec   = (bits_left != 5'd0) ? bits_left - 5'd1 : 5'd0;
  assign run_count = {tok1, tok2} + RUN_MIN;
  assign sum      = {1'b0, produced} + {1'b0, add};

  always_comb begin
    phase_next     = phase;
    stored_next    = stored;
    ctrl_next      = ctrl;
    bits_left_next = bits_left;
    tok0_next      = tok0;
    tok1_next      = tok1;
    tok2_next      = tok2;
    produced_next  = produced;
    cmd_valid      = 1'b0;
    cmd            = '0;
    cmd.kind       = CMD_LIT;
    cmd.data       = in_byte;
    cmd.pos        = pos;
    cmd.count      = 17'd1;
    ignore         = 1'b0;
    tdone          = 1'b0;
    add            = '0;
    if (accept) begin
      if (frame_first) begin
        stored_next    = (in_byte == HDR_STORED);
        produced_next  = '0;
        ctrl_next      = '0;
        bits_left_next = CTRL_BITS;
        phase_next     = (in_byte == HDR_STORED) ? PH_TOKEN : PH_CTRL_HI;
      end else if (phase == PH_HEADER) begin
        ignore = 1'b1;
      end else if (stored) begin
        cmd_valid = 1'b1;
        add       = PROD_W'(1);
      end else begin
        case (phase)
          PH_CTRL_HI: begin
            ctrl_next  = {in_byte, 8'h00};
            phase_next = PH_CTRL_LO;
          end
          PH_CTRL_LO: begin
            ctrl_next      = {ctrl[15:8], in_byte};
            bits_left_next = CTRL_BITS;
            phase_next     = PH_TOKEN;
          end
          PH_TOKEN: begin
            if (ctrl[15]) begin
              tok0_next  = in_byte;
              phase_next = PH_SECOND;
            end else begin
              cmd_valid = 1'b1;
              add       = PROD_W'(1);
              tdone     = 1'b1;
            end
          end
          PH_SECOND: begin
            if (pos != '0) begin
              cmd_valid = 1'b1;
              cmd.kind  = CMD_COPY;
              cmd.count = 17'(in_byte & LEN_MASK) + 17'(COPY_MIN);
              cmd.bad   = {1'b0, pos} > produced;
              add       = PROD_W'(in_byte & LEN_MASK) + PROD_W'(COPY_MIN);
              tdone     = 1'b1;
            end else begin
              tok1_next  = in_byte;
              phase_next = PH_RUN_LO;
            end
          end
          PH_RUN_LO: begin
            tok2_next  = in_byte;
            phase_next = PH_RUN_VAL;
          end
          PH_RUN_VAL: begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_RUN;
            cmd.count = run_count;
            add       = (run_count < 17'(WINDOW_DEPTH)) ? run_count[PROD_W-1:0]
                                                       : PROD_W'(WINDOW_DEPTH);
            tdone     = 1'b1;
          end
          default: begin
            phase_next = PH_HEADER;
          end
        endcase
      end
      if (tdone) begin
        ctrl_next      = {ctrl[14:0], 1'b0};
        bits_left_next = bl_dec;
        phase_next     = (bl_dec == 5'd0) ? PH_CTRL_HI : PH_TOKEN;
      end
      if (!frame_first && !ignore) begin
        produced_next = (sum > (PROD_W+1)'(WINDOW_DEPTH)) ? PROD_W'(WINDOW_DEPTH)
                                                         : sum[PROD_W-1:0];
      end
      cmd.fill = add;
      if (frame_last && !ignore) begin
        if (!cmd_valid) begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_MARK;
          cmd.data  = 8'h00;
          cmd.count = '0;
        end
        cmd.fend    = 1'b1;
        phase_next  = PH_HEADER;
        stored_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      stored    <= 1'b0;
      ctrl      <= '0;
      bits_left <= CTRL_BITS;
      tok0      <= '0;
      tok1      <= '0;
      tok2      <= '0;
      produced  <= '0;
    end else begin
      phase     <= phase_next;
      stored    <= stored_next;
      ctrl      <= ctrl_next;
      bits_left <= bits_left_next;
      tok0      <= tok0_next;
      tok1      <= tok1_next;
      tok2      <= tok2_next;
      produced  <= produced_next;
    end
  end

endmodule

// ----- hdl/lrd_queue.sv -----
// Short command queue between parser and history engine.
module lrd_queue import lrd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   fill;
  logic           push, pop;

  assign wr_ready = (fill != (QAW+1)'(QDEPTH));
  assign rd_valid = (fill != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      fill <= fill + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

// ----- hdl/lrd_back.sv -----
// History engine: executes commands against the 4 KiB window and drives results.
module lrd_back import lrd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  cmd_t         cmd_in,
  output logic         res_valid,
  input  logic         res_ready,
  output logic [7:0]   res_byte,
  output logic [16:0]  res_count,
  output logic         res_last,
  output logic         res_fend,
  output logic         res_bad
);

  logic [7:0]          hist [WINDOW_DEPTH];
  logic [7:0]          rdata;
  logic [HIST_AW-1:0]  wp, wp_next;
  bk_state_t           state, state_next;
  cmd_t                cur, cur_next;
  logic [PROD_W-1:0]   cnt, cnt_next;
  logic                out_free, emit, we, re;
  logic [7:0]          wdata, e_byte;
  logic [16:0]         e_count;
  logic                e_last, e_fend, e_bad;

  assign out_free = !res_valid || res_ready;

  always_comb begin
    state_next = state;
    cur_next   = cur;
    cnt_next   = cnt;
    wp_next    = wp;
    cmd_ready  = 1'b0;
    emit       = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    wdata      = cur.data;
    e_byte     = cur.data;
    e_count    = cur.count;
    e_last     = 1'b1;
    e_fend     = cur.fend;
    e_bad      = 1'b0;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd_in.kind)
            CMD_LIT, CMD_MARK: begin
              if (out_free) begin
                cmd_ready = 1'b1;
                emit      = 1'b1;
                e_byte    = cmd_in.data;
                e_count   = cmd_in.count;
                e_fend    = cmd_in.fend;
                if (cmd_in.kind == CMD_LIT) begin
                  we      = 1'b1;
                  wdata   = cmd_in.data;
                  wp_next = wp + HIST_AW'(1);
                end
              end
            end
            CMD_COPY: begin
              cmd_ready  = 1'b1;
              cur_next   = cmd_in;
              cnt_next   = cmd_in.fill;
              state_next = BK_READ;
            end
            default: begin
              cmd_ready  = 1'b1;
              cur_next   = cmd_in;
              cnt_next   = cmd_in.fill;
              state_next = BK_FILL;
            end
          endcase
        end
      end
      BK_READ: begin
        re         = 1'b1;
        state_next = BK_WRITE;
      end
      BK_WRITE: begin
        if (out_free) begin
          we         = 1'b1;
          wdata      = rdata;
          emit       = 1'b1;
          e_byte     = rdata;
          e_count    = 17'd1;
          e_bad      = cur.bad;
          e_last     = (cnt == PROD_W'(1));
          e_fend     = cur.fend && (cnt == PROD_W'(1));
          wp_next    = wp + HIST_AW'(1);
          cnt_next   = cnt - PROD_W'(1);
          state_next = (cnt == PROD_W'(1)) ? BK_IDLE : BK_READ;
        end
      end
      BK_FILL: begin
        // the final write goes with the result so it is never repeated
        if (cnt != PROD_W'(1) || out_free) begin
          we       = 1'b1;
          wp_next  = wp + HIST_AW'(1);
          cnt_next = cnt - PROD_W'(1);
          if (cnt == PROD_W'(1)) begin
            emit       = 1'b1;
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) hist[wp] <= wdata;
    if (re) rdata <= hist[wp - cur.pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      wp        <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      if (emit)           res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    cnt <= cnt_next;
    if (emit) begin
      res_byte  <= e_byte;
      res_count <= e_count;
      res_last  <= e_last;
      res_fend  <= e_fend;
      res_bad   <= e_bad;
    end
  end

endmodule

// ----- hdl/lzrw1_rle_decompressor_unit.sv -----
// A literal's byte passes through the command queue and the result register; copies do a
//   history read, then a write and result, for each output byte, as the RAM has a single port.
// Runs occupy the history engine while it writes min(count, 4096) window entries.
// Input takes one byte per cycle while the 4-entry command queue has room.
// Synchronous active-high reset clears parser state, queue and write pointer;
//   history contents are not cleared.
module lzrw1_rle_decompressor_unit import lrd_pkg::*; (
  input logic     clk,
  input logic     rst,
  lrd_in_if.sink  comp,
  lrd_out_if.source decomp
);

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  lrd_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(comp.valid), .in_ready(comp.ready), .in_byte(comp.in_byte),
    .frame_first(comp.frame_first), .frame_last(comp.frame_last),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  lrd_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_cmd(b_cmd)
  );

  lrd_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_in(b_cmd),
    .res_valid(decomp.valid), .res_ready(decomp.ready),
    .res_byte(decomp.out_byte), .res_count(decomp.repeat_count),
    .res_last(decomp.last_of_item), .res_fend(decomp.frame_end),
    .res_bad(decomp.bad_offset)
  );

endmodule

// ----- hdl/lrd_checker.sv -----
// Port-level checks on the decompressor's result channel.
module lrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [16:0] repeat_count,
  input logic        last_of_item,
  input logic        frame_end,
  input logic        bad_offset
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(repeat_count))
    else $error("result dropped while stalled");

  a_mark: assert property (@(posedge clk) disable iff (rst)
    valid && repeat_count == 17'd0 |-> last_of_item && frame_end && !bad_offset)
    else $error("end marker malformed");

  a_fend: assert property (@(posedge clk) disable iff (rst)
    valid && frame_end |-> last_of_item)
    else $error("frame end without item end");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    valid && bad_offset |-> repeat_count == 17'd1)
    else $error("bad offset on non-copy result");

  a_rst: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid after reset");

endmodule

bind lzrw1_rle_decompressor_unit lrd_checker u_lrd_checker (
  .clk(clk), .rst(rst),
  .valid(decomp.valid), .ready(decomp.ready),
  .repeat_count(decomp.repeat_count), .last_of_item(decomp.last_of_item),
  .frame_end(decomp.frame_end), .bad_offset(decomp.bad_offset)
);

// ----- dv/lzrw1_rle_decompressor_unit_tb.sv -----
// Self-checking testbench for the LZRW1 run-length decompressor unit.
`timescale 1ns / 100ps

module lzrw1_rle_decompressor_unit_tb import lrd_pkg::*; ();

  typedef struct {
    logic [7:0]  data;
    logic [16:0] cnt;
    logic        last_item;
    logic        fend;
    logic        bad;
  } dec_byte_t;

  // Decoder shadow: tracks parse state and history, and keeps decoded bytes due out
  class decode_board;
    logic [7:0]  hist [WINDOW_DEPTH];
    logic [11:0] wp;
    int          produced;
    int          filled;      // history entries written since reset, saturating
    phase_t      phase;
    bit          stored;
    logic [15:0] ctrl;
    int          bits;
    logic [7:0]  tok [3];
    dec_byte_t   due [$];
    int          errors;

    function new();
      wp = '0; produced = 0; filled = 0; phase = PH_HEADER; stored = 0;
      ctrl = '0; bits = 16; tok = '{default: '0}; errors = 0;
    endfunction

    function void put_hist(logic [7:0] v);
      hist[wp] = v;
      wp++;
      if (filled < WINDOW_DEPTH) filled++;
    endfunction

    function void add_produced(int k);
      produced = (produced + k > WINDOW_DEPTH) ? WINDOW_DEPTH : produced + k;
    endfunction

    function void next_token();
      ctrl = ctrl << 1;
      if (bits > 0) bits--;
      phase = (bits == 0) ? PH_CTRL_HI : PH_TOKEN;
    endfunction

    function void note_input(logic [7:0] b, bit first, bit last);
      dec_byte_t   r [$];
      logic [11:0] pos;
      logic [16:0] cnt;
      int          size, fill;
      logic [7:0]  v;
      bit          bad;
      if (first) begin
        stored = (b == HDR_STORED);
        produced = 0; ctrl = '0; bits = 16; tok = '{default: '0};
        phase = stored ? PH_TOKEN : PH_CTRL_HI;
      end else if (phase == PH_HEADER) begin
        return;  // stray byte, ignored even with last
      end else if (stored) begin
        put_hist(b); add_produced(1);
        r.push_back('{b, 17'd1, 0, 0, 0});
      end else begin
        case (phase)
          PH_CTRL_HI: begin ctrl = {b, 8'h00}; phase = PH_CTRL_LO; end
          PH_CTRL_LO: begin ctrl[7:0] = b; bits = 16; phase = PH_TOKEN; end
          PH_TOKEN: begin
            if (ctrl[15]) begin
              tok[0] = b; phase = PH_SECOND;
            end else begin
              put_hist(b); add_produced(1);
              r.push_back('{b, 17'd1, 0, 0, 0});
              next_token();
            end
          end
          PH_SECOND: begin
            pos = {tok[0], b[7:4]};
            if (pos != 0) begin
              size = int'(b & LEN_MASK) + COPY_MIN;
              bad = (pos > produced);
              for (int k = 0; k < size; k++) begin
                v = hist[wp - pos];
                put_hist(v);
                r.push_back('{v, 17'd1, 0, 0, bad});
              end
              add_produced(size);
              next_token();
            end else begin
              tok[1] = b; phase = PH_RUN_LO;
            end
          end
          PH_RUN_LO: begin tok[2] = b; phase = PH_RUN_VAL; end
          default: begin
            cnt = {1'b0, tok[1], tok[2]} + RUN_MIN;
            fill = (cnt < WINDOW_DEPTH) ? cnt : WINDOW_DEPTH;
            for (int k = 0; k < fill; k++) put_hist(b);
            add_produced(fill);
            r.push_back('{b, cnt, 0, 0, 0});
            next_token();
          end
        endcase
      end
      if (last) begin
        if (r.size() == 0) r.push_back('{8'h00, 17'd0, 0, 0, 0});
        r[$].fend = 1;
        phase = PH_HEADER;
        stored = 0;
      end
      if (r.size() > 0) r[$].last_item = 1;
      foreach (r[i]) due.push_back(r[i]);
    endfunction

    function void check_result(dec_byte_t a);
      dec_byte_t e;
      if (due.size() == 0) begin
        $display("%0t: unexpected item: byte %h count %0d", $realtime, a.data, a.cnt);
        errors++;
        return;
      end
      e = due.pop_front();
      if (a.data !== e.data || a.cnt !== e.cnt || a.last_item !== e.last_item ||
          a.fend !== e.fend || a.bad !== e.bad) begin
        $display("%0t: mismatch exp byte %h cnt %0d last %b fend %b bad %b", $realtime,
                 e.data, e.cnt, e.last_item, e.fend, e.bad);
        $display("%0t:          act byte %h cnt %0d last %b fend %b bad %b", $realtime,
                 a.data, a.cnt, a.last_item, a.fend, a.bad);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  localparam int NUM_RANDOM = 480;

  logic clk = 0;
  logic rst = 1;
  always #4 clk = ~clk;

  lrd_in_if  comp ();
  lrd_out_if decomp ();

  lzrw1_rle_decompressor_unit u_top (.clk(clk), .rst(rst), .comp(comp), .decomp(decomp));

  decode_board board = new();
  bit          quiet = 0;     // no idling in the closing part
  bit          hold_req = 0;
  int          frame_left = 0;
  logic [7:0]  pend_b1;

  // Next byte of a mostly well-formed stream, shaped by the current decode state
  task automatic gen_byte(output logic [7:0] b, output bit first, output bit last);
    int lim, pos;
    first = 0;
    last = 0;
    if (board.phase == PH_HEADER || frame_left == 0) begin
      if (board.phase == PH_HEADER && $urandom_range(0, 19) == 0) begin
        b = 8'($urandom); last = 1'($urandom_range(0, 1));  // stray byte
        return;
      end
      first = 1;
      b = ($urandom_range(0, 3) == 0) ? HDR_STORED : 8'($urandom);
      frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4)
                                                : $urandom_range(5, 70);
    end else if (board.stored) begin
      b = 8'($urandom);
    end else begin
      case (board.phase)
        PH_CTRL_HI, PH_CTRL_LO, PH_RUN_LO, PH_RUN_VAL: b = 8'($urandom);
        PH_SECOND: b = pend_b1;
        default: begin
          if (!board.ctrl[15]) begin
            b = 8'($urandom);
          end else if (board.filled == 0 || $urandom_range(0, 3) == 0) begin
            b = 8'h00;
            pend_b1 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 15)) : 8'h00;
          end else begin
            lim = (board.filled > 4095) ? 4095 : board.filled;
            pos = ($urandom_range(0, 1) == 0) ? $urandom_range(1, (lim < 24) ? lim : 24)
                                              : $urandom_range(1, lim);
            b = 8'(pos >> 4);
            pend_b1 = {4'(pos), 4'($urandom)};
          end
        end
      endcase
    end
    if (!first) begin
      if ($urandom_range(0, 39) == 0) begin
        first = 1;            // header mid-frame
        frame_left = $urandom_range(5, 40);
      end
    end
    frame_left--;
    last = (frame_left == 0) || ($urandom_range(0, 59) == 0);
    if (last) frame_left = 0;
  endtask

  task automatic send(logic [7:0] b, bit first, bit last);
    comp.valid       <= 1;
    comp.in_byte     <= b;
    comp.frame_first <= first;
    comp.frame_last  <= last;
    do @(posedge clk); while (!comp.ready);
    board.note_input(b, first, last);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      comp.valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Directed opening: stray byte, stored extremes, literal/copy/window-filling run,
  // bad offset, end markers on header and control byte, truncated token
  logic [9:0] directed [$] = '{
    {8'h55, 2'b01},
    {8'h80, 2'b10}, {8'h00, 2'b00}, {8'hff, 2'b01},
    {8'h01, 2'b10}, {8'h60, 2'b00}, {8'h00, 2'b00}, {8'hab, 2'b00},
    {8'h00, 2'b00}, {8'h10, 2'b00},
    {8'h00, 2'b00}, {8'h0f, 2'b00}, {8'hff, 2'b00}, {8'h5a, 2'b00},
    {8'hc3, 2'b00},
    {8'h02, 2'b10}, {8'h80, 2'b00}, {8'h00, 2'b00}, {8'h00, 2'b00}, {8'h2f, 2'b01},
    {8'h03, 2'b11},
    {8'h04, 2'b10}, {8'hff, 2'b01},
    {8'h05, 2'b10}, {8'hff, 2'b00}, {8'hff, 2'b00}, {8'h00, 2'b01}
  };

  initial begin
    logic [7:0] b;
    bit         f, l;
    comp.valid = 0; comp.in_byte = '0; comp.frame_first = 0; comp.frame_last = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) begin
      sender_gap();
      send(directed[i][9:2], directed[i][1], directed[i][0]);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 150) hold_req = 1;
      if (i == 300) begin
        comp.valid <= 0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
      end
      if (i == NUM_RANDOM - 80) quiet = 1;
      sender_gap();
      gen_byte(b, f, l);
      send(b, f, l);
    end
    comp.valid <= 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4400) @(posedge clk);
    if (board.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int hold;
    decomp.ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (decomp.valid && decomp.ready)
        board.check_result('{decomp.out_byte, decomp.repeat_count, decomp.last_of_item,
                             decomp.frame_end, decomp.bad_offset});
      if (hold > 0) begin
        hold--;
        decomp.ready <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold = 400;  // long back-pressure so the command queue fills
        decomp.ready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 13);
        decomp.ready <= 0;
      end else begin
        decomp.ready <= 1;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
